// ===== rtl/ptrpd_pkg.sv =====
// Shared types and constants for the planar tile row palette decoder.
`default_nettype none

package ptrpd_pkg;

    // Item kinds on the input channel
    typedef enum logic [1:0] {
        KIND_COLOR  = 2'd0,
        KIND_CLEAR  = 2'd1,
        KIND_DECODE = 2'd2
    } ptrpd_kind_t;

    localparam int COLOR_W  = 15;
    localparam int CHAN_W   = 5;
    localparam int PIX_W    = 8;
    localparam int IDX_W    = 8;
    localparam int POS_W    = 3;
    localparam int PLANES   = 4;
    localparam int ROW_PIX  = 8;

    localparam logic [POS_W-1:0] COL_LAST = 3'd7;

    // Palette write command, issued at the input transfer
    typedef struct packed {
        logic               color_we;
        logic               clear_we;
        logic [IDX_W-1:0]   addr;
        logic [COLOR_W-1:0] color;
        logic               clear_bit;
    } ptrpd_wr_t;

    // Per-pixel palette lookup request
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [POS_W-1:0] pix_x;
        logic [POS_W-1:0] pix_y;
        logic             last;
    } ptrpd_rd_t;

    // Pixel side data held alongside the palette read
    typedef struct packed {
        logic             oob;
        logic             color_vld;
        logic             clear_vld;
        logic [POS_W-1:0] pix_x;
        logic [POS_W-1:0] pix_y;
        logic             last;
    } ptrpd_meta_t;

    // Resolved pixel handed to the output register
    typedef struct packed {
        logic [POS_W-1:0]   pix_x;
        logic [POS_W-1:0]   pix_y;
        logic               is_clear;
        logic [COLOR_W-1:0] color;
        logic               last;
    } ptrpd_lu_t;

endpackage

`default_nettype wire

// ===== rtl/ptrpd_if.sv =====
// Valid/ready channel interfaces for input items and output pixels.
`default_nettype none

interface ptrpd_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [6:0]  entry_index;
    logic [14:0] color_word;
    logic        transparent_set;
    logic [7:0]  plane0;
    logic [7:0]  plane1;
    logic [7:0]  plane2;
    logic [7:0]  plane3;
    logic [2:0]  row;
    logic [6:0]  palette_base;
    logic        flip_h;
    logic        flip_v;

    modport source (
        output valid, kind, entry_index, color_word, transparent_set,
               plane0, plane1, plane2, plane3, row, palette_base, flip_h, flip_v,
        input  ready
    );
    modport sink (
        input  valid, kind, entry_index, color_word, transparent_set,
               plane0, plane1, plane2, plane3, row, palette_base, flip_h, flip_v,
        output ready
    );
endinterface

interface ptrpd_pixel_if;
    logic       valid;
    logic       ready;
    logic [2:0] pix_x;
    logic [2:0] pix_y;
    logic       is_clear;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;

    modport source (
        output valid, pix_x, pix_y, is_clear, red, green, blue, last,
        input  ready
    );
    modport sink (
        input  valid, pix_x, pix_y, is_clear, red, green, blue, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/ptrpd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ptrpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, old data on a same-cycle write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ptrpd_row_seq.sv =====
// Input register and column sequencer: one palette lookup per pixel.
`default_nettype none

module ptrpd_row_seq
    import ptrpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    ptrpd_item_if.sink      items,
    output ptrpd_wr_t       wr,
    output logic            rd_valid,
    input  wire logic       rd_ready,
    output ptrpd_rd_t       rd
);

    logic                           busy_reg, busy_next;
    logic [POS_W-1:0]               col_reg, col_next;
    logic [PLANES-1:0][ROW_PIX-1:0] planes_reg, planes_next;
    logic [POS_W-1:0]               y_reg, y_next;
    logic [6:0]                     base_reg, base_next;
    logic                           fliph_reg, fliph_next;
    logic                           rd_fire;
    logic                           row_done;
    logic                           accept;
    logic [3:0]                     pix_idx;

    // Advance the column on each lookup transfer, load a new row on input transfer
    always_comb
    begin
        busy_next   = busy_reg;
        col_next    = col_reg;
        planes_next = planes_reg;
        y_next      = y_reg;
        base_next   = base_reg;
        fliph_next  = fliph_reg;

        rd_fire     = busy_reg && rd_ready;
        row_done    = rd_fire && (col_reg == COL_LAST);
        items.ready = !busy_reg || row_done;
        accept      = items.valid && items.ready;

        if (rd_fire)
        begin
            col_next = col_reg + 3'd1;
            for (int k = 0; k < PLANES; k++)
            begin
                planes_next[k] = {planes_reg[k][ROW_PIX-2:0], 1'b0};
            end
            if (row_done)
            begin
                busy_next = 1'b0;
            end
        end

        if (accept && (items.kind == KIND_DECODE))
        begin
            busy_next   = 1'b1;
            col_next    = '0;
            planes_next = {items.plane3, items.plane2, items.plane1, items.plane0};
            y_next      = items.flip_v ? ~items.row : items.row;
            base_next   = items.palette_base;
            fliph_next  = items.flip_h;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            col_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            col_reg  <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        planes_reg <= planes_next;
        y_reg      <= y_next;
        base_reg   <= base_next;
        fliph_reg  <= fliph_next;
    end

    // Build the palette writes straight from the transfer
    always_comb
    begin
        wr.color_we  = accept && (items.kind == KIND_COLOR);
        wr.clear_we  = accept && (items.kind == KIND_CLEAR);
        wr.addr      = {1'b0, items.entry_index};
        wr.color     = items.color_word;
        wr.clear_bit = items.transparent_set;
    end

    // Current pixel sits in bit 7 of each plane
    always_comb
    begin
        pix_idx  = {planes_reg[3][ROW_PIX-1], planes_reg[2][ROW_PIX-1],
                    planes_reg[1][ROW_PIX-1], planes_reg[0][ROW_PIX-1]};
        rd_valid = busy_reg;
        rd.idx   = {4'b0, pix_idx} + {1'b0, base_reg};
        rd.pix_x = fliph_reg ? ~col_reg : col_reg;
        rd.pix_y = y_reg;
        rd.last  = (col_reg == COL_LAST);
    end

endmodule

`default_nettype wire

// ===== rtl/ptrpd_palette.sv =====
// Colour and transparency stores with per-entry valid bits and read stage.
`default_nettype none

module ptrpd_palette
    import ptrpd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 128
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ptrpd_wr_t  wr,
    input  wire logic       rd_valid,
    output logic            rd_ready,
    input  wire ptrpd_rd_t  rd,
    output logic            lu_valid,
    input  wire logic       lu_ready,
    output ptrpd_lu_t       lu
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam logic [IDX_W:0] ENTRIES_L = (IDX_W+1)'(PALETTE_ENTRIES);

    logic [PALETTE_ENTRIES-1:0] color_vld_reg, color_vld_next;
    logic [PALETTE_ENTRIES-1:0] clear_vld_reg, clear_vld_next;
    logic                       s1_valid_reg, s1_valid_next;
    ptrpd_meta_t                meta_reg, meta_next;
    logic                       wr_in_range;
    logic                       rd_in_range;
    logic [AW-1:0]              waddr;
    logic [AW-1:0]              raddr;
    logic                       rd_en;
    logic [COLOR_W-1:0]         color_q;
    logic [0:0]                 clear_q;

    assign wr_in_range = ({1'b0, wr.addr} < ENTRIES_L);
    assign rd_in_range = ({1'b0, rd.idx} < ENTRIES_L);
    assign waddr       = wr.addr[AW-1:0];
    assign raddr       = rd.idx[AW-1:0];
    assign rd_ready    = !s1_valid_reg || lu_ready;
    assign rd_en       = rd_valid && rd_ready;

    ptrpd_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_color_ram (
        .clk   (clk),
        .we    (wr.color_we && wr_in_range),
        .waddr (waddr),
        .wdata (wr.color),
        .re    (rd_en && rd_in_range),
        .raddr (raddr),
        .rdata (color_q)
    );

    ptrpd_ram #(
        .WIDTH (1),
        .DEPTH (PALETTE_ENTRIES)
    ) u_clear_ram (
        .clk   (clk),
        .we    (wr.clear_we && wr_in_range),
        .waddr (waddr),
        .wdata (wr.clear_bit),
        .re    (rd_en && rd_in_range),
        .raddr (raddr),
        .rdata (clear_q)
    );

    // Mark entries written since reset; unwritten ones read as zero
    always_comb
    begin
        color_vld_next = color_vld_reg;
        clear_vld_next = clear_vld_reg;
        if (wr.color_we && wr_in_range)
        begin
            color_vld_next[waddr] = 1'b1;
        end
        if (wr.clear_we && wr_in_range)
        begin
            clear_vld_next[waddr] = 1'b1;
        end
    end

    // Capture pixel side data with the read; hold while stalled
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        meta_next     = meta_reg;
        if (rd_en)
        begin
            s1_valid_next       = 1'b1;
            meta_next.oob       = !rd_in_range;
            meta_next.color_vld = rd_in_range && color_vld_reg[raddr];
            meta_next.clear_vld = rd_in_range && clear_vld_reg[raddr];
            meta_next.pix_x     = rd.pix_x;
            meta_next.pix_y     = rd.pix_y;
            meta_next.last      = rd.last;
        end
        else if (lu_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_vld_reg <= '0;
            clear_vld_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            color_vld_reg <= color_vld_next;
            clear_vld_reg <= clear_vld_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meta_reg <= meta_next;
    end

    // Resolve transparency and gate the colour
    always_comb
    begin
        lu_valid    = s1_valid_reg;
        lu.pix_x    = meta_reg.pix_x;
        lu.pix_y    = meta_reg.pix_y;
        lu.last     = meta_reg.last;
        lu.is_clear = meta_reg.oob || (meta_reg.clear_vld && clear_q[0]);
        lu.color    = (!lu.is_clear && meta_reg.color_vld) ? color_q : '0;
    end

endmodule

`default_nettype wire

// ===== rtl/ptrpd_out_stage.sv =====
// Output register: widens BGR555 channels to 8 bits and drives the pixel channel.
`default_nettype none

module ptrpd_out_stage
    import ptrpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       lu_valid,
    output logic            lu_ready,
    input  wire ptrpd_lu_t  lu,
    ptrpd_pixel_if.source   pixels
);

    logic             out_valid_reg, out_valid_next;
    logic [POS_W-1:0] pix_x_reg, pix_x_next;
    logic [POS_W-1:0] pix_y_reg, pix_y_next;
    logic             clear_reg, clear_next;
    logic [PIX_W-1:0] red_reg, red_next;
    logic [PIX_W-1:0] green_reg, green_next;
    logic [PIX_W-1:0] blue_reg, blue_next;
    logic             last_reg, last_next;
    logic             load;

    assign lu_ready = !out_valid_reg || pixels.ready;
    assign load     = lu_valid && lu_ready;

    // Load on transfer in, drop valid once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        pix_x_next     = pix_x_reg;
        pix_y_next     = pix_y_reg;
        clear_next     = clear_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        last_next      = last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            pix_x_next     = lu.pix_x;
            pix_y_next     = lu.pix_y;
            clear_next     = lu.is_clear;
            red_next       = {lu.color[CHAN_W-1:0], 3'b000};
            green_next     = {lu.color[2*CHAN_W-1:CHAN_W], 3'b000};
            blue_next      = {lu.color[3*CHAN_W-1:2*CHAN_W], 3'b000};
            last_next      = lu.last;
        end
        else if (pixels.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_x_reg <= pix_x_next;
        pix_y_reg <= pix_y_next;
        clear_reg <= clear_next;
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        last_reg  <= last_next;
    end

    always_comb
    begin
        pixels.valid    = out_valid_reg;
        pixels.pix_x    = pix_x_reg;
        pixels.pix_y    = pix_y_reg;
        pixels.is_clear = clear_reg;
        pixels.red      = red_reg;
        pixels.green    = green_reg;
        pixels.blue     = blue_reg;
        pixels.last     = last_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/planar_tile_row_palette_decoder_unit.sv =====
// Path: a row's pixels pass the sequencer's row registers, the palette read stage and the
// output register, one per cycle while pixels.ready holds; one palette RAM read per pixel.
// The next item is taken in the cycle the eighth palette read of a row issues.
// Reset: colour and transparency entries read as zero until written (per-entry valid bits
// cleared by rst_n); the stores need no clearing pass, so items are taken right after reset.
`default_nettype none

module planar_tile_row_palette_decoder_unit
    import ptrpd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 128
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ptrpd_item_if.sink    items,
    ptrpd_pixel_if.source pixels
);

    ptrpd_wr_t wr;
    ptrpd_rd_t rd;
    ptrpd_lu_t lu;
    logic      rd_valid;
    logic      rd_ready;
    logic      lu_valid;
    logic      lu_ready;

    ptrpd_row_seq u_row_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .wr       (wr),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd       (rd)
    );

    ptrpd_palette #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd       (rd),
        .lu_valid (lu_valid),
        .lu_ready (lu_ready),
        .lu       (lu)
    );

    ptrpd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .lu_valid (lu_valid),
        .lu_ready (lu_ready),
        .lu       (lu),
        .pixels   (pixels)
    );

endmodule

`default_nettype wire
